// ===== rtl/huffman_tree_bit_decoder_core_defines.svh =====
// Assertion macros shared by the tree-walk decoder RTL.
// Each macro expands to a clocked concurrent assertion, or to nothing in synthesis.
// The asserting module must have signals named clock and reset in scope.
`ifndef HUFFMAN_TREE_BIT_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_BIT_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define HTBD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define HTBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HTBD_ASSERT_IMPLY(label, ante, cons, msg)
`define HTBD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/htbd_pkg.sv =====
// Shared types and constants of the tree-walk decoder.
// Holds the node record, the result record and the request codes.
// Depends on nothing; all other files import it but htbd_ram and the macro header.
`timescale 1ns / 1ps

package htbd_pkg;

   // Field widths fixed by the interface.
   localparam int IDX_W = 9;
   localparam int SYM_W = 32;

   // Node table size and the number of meaningful symbol bits.
   localparam int NODE_COUNT   = 512;
   localparam int NODE_AW      = $clog2(NODE_COUNT);
   localparam int SYMBOL_WIDTH = 32;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [SYM_W-1:0] sym_type;

   localparam sym_type SYM_MASK = sym_type'((64'd1 << SYMBOL_WIDTH) - 64'd1);

   // Request codes.
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // One node table entry.
   typedef struct packed {
      logic    leaf;
      idx_type left;
      idx_type right;
      sym_type symbol;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   // One decode result.
   typedef struct packed {
      sym_type symbol_out;
      logic    symbol_valid;
      logic    end_flag;
      logic    walk_error;
   } result_type;

   // True when an index addresses an entry inside the node table.
   function automatic logic in_table(idx_type idx);
      return (32'(idx) < 32'(NODE_COUNT));
   endfunction

endpackage

// ===== rtl/htbd_req_if.sv =====
// Request channel of the tree-walk decoder: node writes and code bits.
// Depends on htbd_pkg for the field types.
`timescale 1ns / 1ps

interface htbd_req_if;
   import htbd_pkg::*;

   logic    valid;
   logic    ready;
   logic    req_type;
   idx_type node_addr;
   logic    node_is_leaf;
   idx_type node_left;
   idx_type node_right;
   sym_type node_symbol;
   logic    code_bit;
   logic    stream_end;

   modport source (
      output valid, req_type, node_addr, node_is_leaf, node_left, node_right,
             node_symbol, code_bit, stream_end,
      input  ready
   );

   modport sink (
      input  valid, req_type, node_addr, node_is_leaf, node_left, node_right,
             node_symbol, code_bit, stream_end,
      output ready
   );
endinterface

// ===== rtl/htbd_rsp_if.sv =====
// Result channel of the tree-walk decoder: one transaction per decoded bit.
// Depends on htbd_pkg for the symbol type.
`timescale 1ns / 1ps

interface htbd_rsp_if;
   import htbd_pkg::*;

   logic    valid;
   logic    ready;
   sym_type symbol_out;
   logic    symbol_valid;
   logic    end_flag;
   logic    walk_error;

   modport source (
      output valid, symbol_out, symbol_valid, end_flag, walk_error,
      input  ready
   );

   modport sink (
      input  valid, symbol_out, symbol_valid, end_flag, walk_error,
      output ready
   );
endinterface

// ===== rtl/htbd_csr_if.sv =====
// Configuration write channel of the tree-walk decoder: the root index.
// Depends on htbd_pkg for the index type.
`timescale 1ns / 1ps

interface htbd_csr_if;
   import htbd_pkg::*;

   logic    valid;
   logic    ready;
   idx_type root_index;

   modport source (
      output valid, root_index,
      input  ready
   );

   modport sink (
      input  valid, root_index,
      output ready
   );
endinterface

// ===== rtl/huffman_tree_bit_decoder_core.sv =====
// Top level of the bit-serial Huffman tree-walk decoder.
// Depends on htbd_pkg, the three channel interfaces, htbd_walk and htbd_rsp_reg.
//
// Usage:
//  - req_port carries node writes (req_type 0) and code bits (req_type 1).
//    A node write loads one entry of the 512-entry node table and gives no
//    result; each code bit gives exactly one transaction on rsp_port.
//  - csr_port writes the root index; the walk moves to the new root. The
//    following cycle fetches the root entry from the table, and req_port is
//    not ready during it. Write the root only while the decoder is idle.
//  - Throughput is one request per cycle while rsp_port takes results and no
//    root reload runs. A code bit reads one child entry from the node table,
//    while the current and root entries are held in registers, so the next
//    bit can follow in the next cycle.
//  - A bit passes the lookup stage, then the output register, to rsp_port.
//  - When rsp_port stalls, the output register holds its transaction and the
//    lookup stage keeps one more; req_port drops ready once both are full.
//  - Reset returns the root register and the walk to index 0 and empties
//    the pipeline; table contents stay undefined until written.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_core (
   input  logic        clock,
   input  logic        reset,
   htbd_req_if.sink    req_port,
   htbd_rsp_if.source  rsp_port,
   htbd_csr_if.sink    csr_port
);
   import htbd_pkg::*;

   logic       res_valid;
   logic       res_ready;
   result_type res;

   htbd_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .csr_port  (csr_port),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   htbd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .rsp_port  (rsp_port)
   );

endmodule

// ===== rtl/htbd_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; used for the node table.
`timescale 1ns / 1ps

module htbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/htbd_walk.sv =====
// Tree walk engine: node table RAM, current and root node caches, two-stage pipe.
// Depends on htbd_pkg, htbd_ram, the request and configuration interfaces
// and the assertion macro header.
`timescale 1ns / 1ps
`include "huffman_tree_bit_decoder_core_defines.svh"

module htbd_walk (
   input  logic                clock,
   input  logic                reset,
   htbd_req_if.sink            req_port,
   htbd_csr_if.sink            csr_port,
   output logic                res_valid,
   output htbd_pkg::result_type res,
   input  logic                res_ready
);
   import htbd_pkg::*;

   // Root register and the one-cycle root reload after a root write.
   idx_type  root_ff, root_in;
   logic     reload_ff, reload_in;

   // Cached copies of the current node and of the root node.
   idx_type  cur_pos_ff, cur_pos_in;
   node_type cur_node_ff, cur_node_in;
   node_type root_node_ff, root_node_in;

   // Lookup stage: the bit waiting for its child entry from the RAM.
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_err_ff, s1_err_in;
   logic     s1_bad_ff, s1_bad_in;
   logic     s1_end_ff, s1_end_in;
   idx_type  s1_next_ff, s1_next_in;

   logic     accept, dec_acc, wr_acc, csr_acc, wr_hit, s1_adv;
   node_type wnode, rd;
   idx_type  new_pos, eff_pos, next_idx;
   node_type new_node, eff_node;
   logic     to_root;
   logic     ram_re, ram_we;
   logic [NODE_AW-1:0] ram_raddr;
   logic [NODE_W-1:0]  ram_rdata;

   // Handshakes.
   assign csr_port.ready = 1'b1;
   assign csr_acc  = csr_port.valid;
   assign s1_adv   = s1_valid_ff && res_ready;
   assign req_port.ready = !reload_ff && (!s1_valid_ff || res_ready);
   assign accept   = req_port.valid && req_port.ready;
   assign dec_acc  = accept && (req_port.req_type == REQ_DECODE);
   assign wr_acc   = accept && (req_port.req_type == REQ_WRITE);
   assign wr_hit   = wr_acc && in_table(req_port.node_addr);

   assign wnode = '{leaf:   req_port.node_is_leaf,
                    left:   req_port.node_left,
                    right:  req_port.node_right,
                    symbol: req_port.node_symbol};
   assign rd    = node_type'(ram_rdata);

   // Lookup stage resolution: classify the child and work out the next position.
   always_comb begin
      res              = '0;
      res.end_flag     = s1_end_ff;
      res.walk_error   = s1_err_ff || s1_bad_ff;
      to_root          = 1'b1;
      if (!s1_err_ff && !s1_bad_ff) begin
         if (rd.leaf) begin
            res.symbol_valid = 1'b1;
            res.symbol_out   = rd.symbol & SYM_MASK;
         end else begin
            to_root = 1'b0;
         end
      end
      new_pos  = to_root ? root_ff : s1_next_ff;
      new_node = to_root ? root_node_ff : rd;
      if (s1_end_ff) begin
         if (new_pos != root_ff) begin
            res.walk_error = 1'b1;
         end
         new_pos  = root_ff;
         new_node = root_node_ff;
      end
   end

   assign res_valid = s1_valid_ff;

   // The node a newly accepted bit starts from, forwarded from the lookup stage.
   assign eff_pos  = s1_valid_ff ? new_pos : cur_pos_ff;
   assign eff_node = s1_valid_ff ? new_node : cur_node_ff;
   assign next_idx = req_port.code_bit ? eff_node.right : eff_node.left;

   // Entry stage: register the bit and issue the child read.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_err_in   = s1_err_ff;
      s1_bad_in   = s1_bad_ff;
      s1_end_in   = s1_end_ff;
      s1_next_in  = s1_next_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (dec_acc) begin
         s1_valid_in = 1'b1;
         s1_err_in   = eff_node.leaf || !in_table(eff_pos);
         s1_bad_in   = !in_table(next_idx);
         s1_end_in   = req_port.stream_end;
         s1_next_in  = next_idx;
      end
   end

   // Node and root caches; a node write later in order overrides the cached copy.
   always_comb begin
      cur_pos_in   = s1_adv ? new_pos : cur_pos_ff;
      cur_node_in  = s1_adv ? new_node : cur_node_ff;
      root_node_in = root_node_ff;
      root_in      = root_ff;
      reload_in    = 1'b0;
      if (reload_ff) begin
         root_node_in = rd;
         cur_node_in  = rd;
      end
      if (wr_hit && (req_port.node_addr == cur_pos_in)) begin
         cur_node_in = wnode;
      end
      if (wr_hit && (req_port.node_addr == root_ff)) begin
         root_node_in = wnode;
      end
      if (csr_acc) begin
         root_in    = csr_port.root_index;
         cur_pos_in = csr_port.root_index;
         reload_in  = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff     <= '0;
         cur_pos_ff  <= '0;
         reload_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         root_ff     <= root_in;
         cur_pos_ff  <= cur_pos_in;
         reload_ff   <= reload_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_node_ff  <= cur_node_in;
      root_node_ff <= root_node_in;
      s1_err_ff    <= s1_err_in;
      s1_bad_ff    <= s1_bad_in;
      s1_end_ff    <= s1_end_in;
      s1_next_ff   <= s1_next_in;
   end

   // Node table; a root write takes the read port to fetch the new root entry.
   assign ram_we    = wr_hit;
   assign ram_re    = dec_acc || csr_acc;
   assign ram_raddr = csr_acc ? NODE_AW'(csr_port.root_index) : NODE_AW'(next_idx);

   htbd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (NODE_AW'(req_port.node_addr)),
      .wdata (wnode),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Assertions.
   `HTBD_ASSERT_IMPLY(a_reload_blocks, reload_ff, !req_port.ready, "request taken during root reload")
   `HTBD_ASSERT_NEXT(a_decode_enters, dec_acc, s1_valid_ff, "accepted bit missing from lookup stage")
   `HTBD_ASSERT_NEXT(a_stall_holds, s1_valid_ff && !res_ready, s1_valid_ff && $stable(s1_next_ff), "stalled lookup stage lost its bit")
   `HTBD_ASSERT_IMPLY(a_symbol_no_error, s1_valid_ff && res.symbol_valid, !res.walk_error, "symbol reported together with an error")

endmodule

// ===== rtl/htbd_rsp_reg.sv =====
// Output register of the tree-walk decoder; decouples the result channel.
// Depends on htbd_pkg and the result interface.
`timescale 1ns / 1ps

module htbd_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  htbd_pkg::result_type res,
   output logic                 res_ready,
   htbd_rsp_if.source           rsp_port
);
   import htbd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       load;

   // The register takes a new result when empty or when it is being emptied.
   assign res_ready = !out_valid_ff || rsp_port.ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      out_in       = load ? res : out_ff;
      out_valid_in = load ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.symbol_out   = out_ff.symbol_out;
   assign rsp_port.symbol_valid = out_ff.symbol_valid;
   assign rsp_port.end_flag     = out_ff.end_flag;
   assign rsp_port.walk_error   = out_ff.walk_error;

endmodule

// ===== test/huffman_tree_bit_decoder_core_checker.sv =====
// Checker for the tree-walk decoder: watches the request, result and root channels.
// Keeps its own copy of the node table and the walk, predicts each decode result and
// compares it. Depends on htbd_pkg and the three channel interfaces.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_core_checker (
   input  logic clock,
   input  logic reset,
   htbd_req_if  req,
   htbd_rsp_if  rsp,
   htbd_csr_if  csr,
   output int   mismatches,
   output int   outstanding
);
   import htbd_pkg::*;

   // Mirror of the decoder state.
   node_type   tree_copy [NODE_COUNT];
   idx_type    root_copy;
   idx_type    walk_pos;
   result_type pending_results [$];

   // One line per mismatch, and the count goes up by one.
   task automatic report_mismatch(input string what);
      mismatches++;
      $display("ERROR at %0t ns: %s", $time, what);
   endtask

   // Steps the walk by one code bit and returns the result that bit should give.
   function automatic result_type walk_one_bit(input logic bit_val, input logic last);
      result_type res;
      idx_type    next_pos;
      res          = '0;
      res.end_flag = last;
      if (int'(walk_pos) >= NODE_COUNT || tree_copy[walk_pos].leaf) begin
         // A bit at a leaf or outside the table: flagged, and the walk restarts at the root.
         res.walk_error = 1'b1;
         walk_pos       = root_copy;
      end else begin
         next_pos = bit_val ? tree_copy[walk_pos].right : tree_copy[walk_pos].left;
         if (int'(next_pos) >= NODE_COUNT) begin
            res.walk_error = 1'b1;
            walk_pos       = root_copy;
         end else if (tree_copy[next_pos].leaf) begin
            res.symbol_out   = tree_copy[next_pos].symbol & SYM_MASK;
            res.symbol_valid = 1'b1;
            walk_pos         = root_copy;
         end else begin
            walk_pos = next_pos;
         end
      end
      // The end of a stream must find the walk back at the root.
      if (last) begin
         if (walk_pos != root_copy) begin
            res.walk_error = 1'b1;
         end
         walk_pos = root_copy;
      end
      return res;
   endfunction

   // Every transaction is taken at the rising edge at which valid and ready are both high.
   always @(posedge clock) begin
      result_type want;
      result_type predicted;
      if (reset) begin
         for (int i = 0; i < NODE_COUNT; i++) begin
            tree_copy[i] = '0;
         end
         root_copy = '0;
         walk_pos  = '0;
         pending_results.delete();
      end else begin
         // Results first: none can stem from a request taken at the same edge.
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result transaction with no decode bit waiting");
            end else begin
               want = pending_results.pop_front();
               if (rsp.symbol_out !== want.symbol_out) begin
                  report_mismatch($sformatf("symbol_out %h, expected %h",
                                            rsp.symbol_out, want.symbol_out));
               end
               if (rsp.symbol_valid !== want.symbol_valid) begin
                  report_mismatch($sformatf("symbol_valid %b, expected %b",
                                            rsp.symbol_valid, want.symbol_valid));
               end
               if (rsp.end_flag !== want.end_flag) begin
                  report_mismatch($sformatf("end_flag %b, expected %b",
                                            rsp.end_flag, want.end_flag));
               end
               if (rsp.walk_error !== want.walk_error) begin
                  report_mismatch($sformatf("walk_error %b, expected %b",
                                            rsp.walk_error, want.walk_error));
               end
            end
         end

         // A root write also moves the walk to the new root.
         if (csr.valid && csr.ready) begin
            root_copy = csr.root_index;
            walk_pos  = csr.root_index;
         end

         if (req.valid && req.ready) begin
            if (req.req_type == REQ_WRITE) begin
               if (int'(req.node_addr) < NODE_COUNT) begin
                  tree_copy[req.node_addr].leaf   = req.node_is_leaf;
                  tree_copy[req.node_addr].left   = req.node_left;
                  tree_copy[req.node_addr].right  = req.node_right;
                  tree_copy[req.node_addr].symbol = req.node_symbol;
               end
            end else begin
               predicted       = walk_one_bit(req.code_bit, req.stream_end);
               pending_results = {pending_results, predicted};
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// ===== test/huffman_tree_bit_decoder_core_tb.sv =====
// Testbench top for the tree-walk decoder: clock, reset, stimulus and the verdict.
// Loads a full node table, walks it with well-formed and broken code streams under
// random stalls. Depends on htbd_pkg, the channel interfaces, the core and the checker.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_core_tb;
   import htbd_pkg::*;

   localparam int IDLE_PERCENT = 22;
   localparam int LEAF_PERCENT = 40;
   localparam int MAX_CODE_LEN = 12;
   localparam int HOLD_CYCLES  = 80;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_ITEMS  = 125;

   logic clock;
   logic reset;

   htbd_req_if req_ch ();
   htbd_rsp_if rsp_ch ();
   htbd_csr_if csr_ch ();

   int mismatches;
   int outstanding;

   // Traffic shaping for the sender and the receiver, and progress counters.
   bit req_no_idle;
   bit rsp_no_idle;
   bit rsp_hold;
   int items_sent;
   int quiet_cycles;

   // The tree as the stimulus has written it, used to steer code streams along real paths.
   node_type node_plan [NODE_COUNT];
   idx_type  plan_root;

   huffman_tree_bit_decoder_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   huffman_tree_bit_decoder_core_checker decode_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr         (csr_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Clock with a 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic node_type random_node();
      node_type nd;
      nd.leaf   = ($urandom_range(0, 99) < LEAF_PERCENT);
      nd.left   = idx_type'($urandom_range(0, NODE_COUNT - 1));
      nd.right  = idx_type'($urandom_range(0, NODE_COUNT - 1));
      nd.symbol = $urandom;
      return nd;
   endfunction

   function automatic idx_type pick_inner_node();
      idx_type cand;
      cand = idx_type'($urandom_range(0, NODE_COUNT - 1));
      for (int tries = 0; tries < 64 && node_plan[cand].leaf; tries++) begin
         cand = idx_type'($urandom_range(0, NODE_COUNT - 1));
      end
      return cand;
   endfunction

   // Offers one request transaction, with random idle cycles ahead of it, and waits
   // until it is taken. Called and returning at a falling edge.
   task automatic send_item(input logic kind, input idx_type addr, input node_type nd,
                            input logic bit_val, input logic last);
      while (!req_no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.node_addr    <= addr;
      req_ch.node_is_leaf <= nd.leaf;
      req_ch.node_left    <= nd.left;
      req_ch.node_right   <= nd.right;
      req_ch.node_symbol  <= nd.symbol;
      req_ch.code_bit     <= bit_val;
      req_ch.stream_end   <= last;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Node write; the bit fields carry noise that the block must ignore.
   task automatic send_node(input idx_type addr, input node_type nd);
      node_plan[addr] = nd;
      send_item(REQ_WRITE, addr, nd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // Decode bit; the node fields carry noise.
   task automatic send_bit(input logic bit_val, input logic last);
      send_item(REQ_DECODE, idx_type'($urandom_range(0, NODE_COUNT - 1)), random_node(),
                bit_val, last);
   endtask

   // Random path from the root to a leaf. A walk that finds no leaf in time is cut off,
   // which leaves the stream mid-codeword.
   task automatic send_codeword(input logic last);
      idx_type pos;
      idx_type nxt;
      logic    b;
      pos = plan_root;
      for (int depth = 1; depth <= MAX_CODE_LEN; depth++) begin
         b   = 1'($urandom_range(0, 1));
         nxt = b ? node_plan[pos].right : node_plan[pos].left;
         if (node_plan[pos].leaf || node_plan[nxt].leaf || depth == MAX_CODE_LEN) begin
            send_bit(b, last);
            return;
         end
         send_bit(b, 1'b0);
         pos = nxt;
      end
   endtask

   // Stops offering, waits for every expected result, then lets the extra cycles
   // given by the caller pass.
   task automatic drain(input int extra);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_root(input idx_type new_root);
      drain(4);
      csr_ch.valid      <= 1'b1;
      csr_ch.root_index <= new_root;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      plan_root = new_root;
   endtask

   // Receiver: random stalls, a stretch without any, and one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
         end else begin
            rsp_ch.ready <= rsp_no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
            @(negedge clock);
         end
      end
   end

   // Watchdog: ends the run once no transaction has been taken for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Stimulus.
   initial begin
      int      phase_start;
      int      roll;
      int      words;
      logic    finish_stream;
      bit      paused;
      idx_type new_root;

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_WRITE;
      req_ch.node_addr    = '0;
      req_ch.node_is_leaf = 1'b0;
      req_ch.node_left    = '0;
      req_ch.node_right   = '0;
      req_ch.node_symbol  = '0;
      req_ch.code_bit     = 1'b0;
      req_ch.stream_end   = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.root_index   = '0;
      req_no_idle         = 1'b0;
      rsp_no_idle         = 1'b0;
      rsp_hold            = 1'b0;
      items_sent          = 0;
      plan_root           = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Load every entry first, so no walk ever reads an entry that was never written.
      for (int a = 0; a < NODE_COUNT; a++) begin
         send_node(idx_type'(a), random_node());
      end

      // Hand-built tree at the table ends: from node 0, 0 gives symbol zero, 10 gives
      // all ones and 11 gives a pattern.
      send_node(9'd1, '{1'b1, 9'd0, 9'd0, 32'h0000_0000});
      send_node(9'd2, '{1'b1, 9'd511, 9'd511, 32'hFFFF_FFFF});
      send_node(9'd3, '{1'b1, 9'd0, 9'd0, 32'hA5A5_5A5A});
      send_node(9'd511, '{1'b0, 9'd2, 9'd3, 32'h0000_0000});
      send_node(9'd0, '{1'b0, 9'd1, 9'd511, 32'hFFFF_FFFF});
      write_root(9'd0);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b1);
      // Stream ending mid-codeword, then a clean one-bit stream.
      send_bit(1'b1, 1'b1);
      send_bit(1'b0, 1'b1);
      // The node under the walk turns into a leaf: the next bit arrives at a leaf.
      send_bit(1'b1, 1'b0);
      send_node(9'd511, '{1'b1, 9'd0, 9'd0, 32'h1234_5678});
      send_bit(1'b0, 1'b0);
      send_node(9'd511, '{1'b0, 9'd2, 9'd3, 32'h0000_0000});
      // Root at the top index.
      write_root(9'd511);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
      // Root on a leaf: every bit arrives at a leaf and is flagged.
      write_root(9'd2);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b1);

      // Random phases, each under its own root and traffic shape.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       new_root = '0;
            1, 5:    new_root = '1;
            default: new_root = pick_inner_node();
         endcase
         write_root(new_root);
         req_no_idle = (phase == 1) || (phase == 2);
         rsp_no_idle = (phase == 1);
         if (phase == 2) begin
            rsp_hold = 1'b1;
         end
         phase_start = items_sent;
         paused      = 1'b0;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            // Halfway through one phase the sender waits for every result.
            if (phase == 3 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
               drain(1);
               paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
               words         = $urandom_range(1, 4);
               finish_stream = ($urandom_range(0, 99) < 85);
               for (int w = 1; w <= words; w++) begin
                  send_codeword(finish_stream && w == words);
               end
            end else if (roll < 87) begin
               send_node(idx_type'($urandom_range(0, NODE_COUNT - 1)), random_node());
            end else begin
               send_bit(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
            end
         end
      end

      // Wait for the tail of results, then give the verdict.
      drain(8);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
